/* rtl/core/mfp_pkg.sv */
package mfp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ABORT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TCP_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_AS_REQUEST = 1'b1;

	localparam logic [BYTE_W-1:0] FC_WRITE_COIL  = 8'd5;
	localparam logic [BYTE_W-1:0] FC_WRITE_REG   = 8'd6;
	localparam logic [BYTE_W-1:0] FC_WRITE_COILS = 8'd15;
	localparam logic [BYTE_W-1:0] FC_WRITE_REGS  = 8'd16;

	localparam logic [WORD_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic tcp_mode;
		logic as_request;
	} cfg_t;

	typedef struct packed {
		logic              complete;
		logic              corrupt;
		logic [BYTE_W-1:0] unit_id;
		logic [BYTE_W-1:0] function_code;
		logic [WORD_W-1:0] start_address;
		logic [WORD_W-1:0] quantity;
		logic [BYTE_W-1:0] exception_code;
		logic [WORD_W-1:0] transaction_id;
		logic [WORD_W-1:0] pdu_length;
		logic [WORD_W-1:0] crc_word;
		logic [WORD_W-1:0] bytes_seen;
	} res_t;

	function automatic logic is_write_code(input logic [BYTE_W-1:0] c);
		return (c == FC_WRITE_COIL) || (c == FC_WRITE_REG) ||
			(c == FC_WRITE_COILS) || (c == FC_WRITE_REGS);
	endfunction

endpackage

/* rtl/core/mfp_byte_if.sv */
interface mfp_byte_if;
	logic                         valid;
	logic                         ready;
	logic [mfp_pkg::FUNC_W-1:0]   func;
	logic [mfp_pkg::BYTE_W-1:0]   data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

/* rtl/core/mfp_result_if.sv */
interface mfp_result_if;
	logic                       valid;
	logic                       ready;
	logic                       complete;
	logic                       corrupt;
	logic [mfp_pkg::BYTE_W-1:0] unit_id;
	logic [mfp_pkg::BYTE_W-1:0] function_code;
	logic [mfp_pkg::WORD_W-1:0] start_address;
	logic [mfp_pkg::WORD_W-1:0] quantity;
	logic [mfp_pkg::BYTE_W-1:0] exception_code;
	logic [mfp_pkg::WORD_W-1:0] transaction_id;
	logic [mfp_pkg::WORD_W-1:0] pdu_length;
	logic [mfp_pkg::WORD_W-1:0] crc_word;
	logic [mfp_pkg::WORD_W-1:0] bytes_seen;

	modport source (output valid, output complete, output corrupt, output unit_id,
		output function_code, output start_address, output quantity,
		output exception_code, output transaction_id, output pdu_length,
		output crc_word, output bytes_seen, input ready);
	modport sink (input valid, input complete, input corrupt, input unit_id,
		input function_code, input start_address, input quantity,
		input exception_code, input transaction_id, input pdu_length,
		input crc_word, input bytes_seen, output ready);
endinterface

/* rtl/core/mfp_parse.sv */
module mfp_parse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [mfp_pkg::FUNC_W-1:0]   func,
	input  logic [mfp_pkg::BYTE_W-1:0]   data_byte,
	input  mfp_pkg::cfg_t                cfg,
	output mfp_pkg::res_t                result
);

	typedef enum logic [3:0] {
		ST_UNIT  = 4'd0,
		ST_FUNC  = 4'd1,
		ST_ADDR  = 4'd2,
		ST_QTY   = 4'd3,
		ST_COUNT = 4'd4,
		ST_BODY  = 4'd5,
		ST_CRC   = 4'd6,
		ST_EXC   = 4'd7,
		ST_DONE  = 4'd8,
		ST_BAD   = 4'd9,
		ST_TXID  = 4'd10,
		ST_PROTO = 4'd11,
		ST_LEN   = 4'd12
	} state_t;

	state_t                     state_q, state_d;
	logic                       held_q, held_d;
	logic [mfp_pkg::BYTE_W-1:0] last_q, last_d;
	logic [mfp_pkg::BYTE_W-1:0] unit_q, unit_d;
	logic [mfp_pkg::BYTE_W-1:0] fcode_q, fcode_d;
	logic [mfp_pkg::WORD_W-1:0] addr_q, addr_d;
	logic [mfp_pkg::WORD_W-1:0] qty_q, qty_d;
	logic [mfp_pkg::BYTE_W-1:0] exc_q, exc_d;
	logic [mfp_pkg::WORD_W-1:0] txn_q, txn_d;
	logic [mfp_pkg::WORD_W-1:0] len_q, len_d;
	logic [mfp_pkg::WORD_W-1:0] crc_q, crc_d;
	logic [mfp_pkg::BYTE_W-1:0] body_q, body_d;
	logic [mfp_pkg::WORD_W-1:0] cnt_q, cnt_d;

	logic [mfp_pkg::WORD_W-1:0] word;
	logic [mfp_pkg::BYTE_W-1:0] body_dec;
	logic                       count_ok;

	assign word     = {last_q, data_byte};
	assign body_dec = body_q - 8'd1;
	// twice the quantity, no truncation: only quantities below 128 can match
	assign count_ok = (qty_q[15:7] == 9'd0) && (qty_q[6:0] == data_byte[7:1]) &&
		!data_byte[0];

	always_comb begin
		state_d = state_q;
		held_d  = held_q;
		last_d  = last_q;
		unit_d  = unit_q;
		fcode_d = fcode_q;
		addr_d  = addr_q;
		qty_d   = qty_q;
		exc_d   = exc_q;
		txn_d   = txn_q;
		len_d   = len_q;
		crc_d   = crc_q;
		body_d  = body_q;
		cnt_d   = cnt_q;
		case (func)
			mfp_pkg::FUNC_DATA: begin
				if (state_q != ST_BAD && cnt_q != mfp_pkg::COUNT_MAX)
					cnt_d = cnt_q + 16'd1;
				last_d = data_byte;
				case (state_q)
					ST_EXC: begin
						exc_d   = data_byte;
						state_d = ST_CRC;
					end
					ST_TXID: begin
						held_d = !held_q;
						if (held_q) begin
							txn_d   = word;
							state_d = ST_PROTO;
						end
					end
					ST_PROTO: begin
						held_d = !held_q;
						if (held_q) begin
							crc_d   = word;
							state_d = (word != 16'd0) ? ST_BAD : ST_LEN;
						end
					end
					ST_LEN: begin
						held_d = !held_q;
						if (held_q) begin
							len_d   = word;
							state_d = ST_UNIT;
						end
					end
					ST_UNIT: begin
						unit_d  = data_byte;
						state_d = ST_FUNC;
					end
					ST_FUNC: begin
						fcode_d = data_byte;
						if (cfg.as_request)
							state_d = ST_ADDR;
						else if (data_byte[mfp_pkg::BYTE_W-1])
							state_d = ST_EXC;
						else if (mfp_pkg::is_write_code(data_byte))
							state_d = ST_ADDR;
						else
							state_d = ST_COUNT;
					end
					ST_ADDR: begin
						held_d = !held_q;
						if (held_q) begin
							addr_d  = word;
							state_d = ST_QTY;
						end
					end
					ST_QTY: begin
						held_d = !held_q;
						if (held_q) begin
							qty_d   = word;
							state_d = (cfg.as_request == mfp_pkg::is_write_code(fcode_q)) ?
								ST_COUNT : ST_CRC;
						end
					end
					ST_COUNT: begin
						if (count_ok) begin
							body_d  = data_byte;
							state_d = (data_byte != 8'd0) ? ST_BODY : ST_CRC;
						end else begin
							state_d = ST_BAD;
						end
					end
					ST_BODY: begin
						body_d = body_dec;
						if (body_dec == 8'd0)
							state_d = cfg.tcp_mode ? ST_DONE : ST_CRC;
					end
					ST_CRC: begin
						held_d = !held_q;
						if (held_q) begin
							crc_d   = word;
							state_d = ST_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			mfp_pkg::FUNC_START: begin
				state_d = cfg.tcp_mode ? ST_TXID : ST_UNIT;
				held_d  = 1'b0;
				unit_d  = '0;
				addr_d  = '0;
				qty_d   = '0;
				exc_d   = '0;
				body_d  = '0;
				cnt_d   = '0;
			end
			mfp_pkg::FUNC_ABORT: begin
				state_d = ST_BAD;
				held_d  = 1'b0;
			end
			default: begin
			end
		endcase
		// no CRC trailer in TCP framing
		if (cfg.tcp_mode && state_d == ST_CRC)
			state_d = ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_UNIT;
			held_q  <= 1'b0;
			last_q  <= '0;
			unit_q  <= '0;
			fcode_q <= '0;
			addr_q  <= '0;
			qty_q   <= '0;
			exc_q   <= '0;
			txn_q   <= '0;
			len_q   <= '0;
			crc_q   <= '0;
			body_q  <= '0;
			cnt_q   <= '0;
		end else if (fire) begin
			state_q <= state_d;
			held_q  <= held_d;
			last_q  <= last_d;
			unit_q  <= unit_d;
			fcode_q <= fcode_d;
			addr_q  <= addr_d;
			qty_q   <= qty_d;
			exc_q   <= exc_d;
			txn_q   <= txn_d;
			len_q   <= len_d;
			crc_q   <= crc_d;
			body_q  <= body_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		result.complete       = (state_d == ST_DONE);
		result.corrupt        = (state_d == ST_BAD);
		result.unit_id        = unit_d;
		result.function_code  = fcode_d;
		result.start_address  = addr_d;
		result.quantity       = qty_d;
		result.exception_code = exc_d;
		result.transaction_id = txn_d;
		result.pdu_length     = len_d;
		result.crc_word       = crc_d;
		result.bytes_seen     = cnt_d;
	end

endmodule

/* rtl/core/mfp_outq.sv */
module mfp_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mfp_pkg::res_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output mfp_pkg::res_t data
);

	mfp_pkg::res_t entry0_q, entry1_q;
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign data  = rd_ptr_q ? entry1_q : entry0_q;

	always_ff @(posedge clk) begin
		if (push && !wr_ptr_q)
			entry0_q <= push_data;
		if (push && wr_ptr_q)
			entry1_q <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* rtl/core/modbus_frame_parser.sv */
// Modbus frame parser, RTU or TCP framing.
// rx carries one word per frame byte or event: func selects a data byte, a
// frame start or an abort, data_byte holds the byte. res gives one word for
// every rx word, showing the frame fields and status after that word.
// Both channels use valid/ready; a word moves when both are high.
// Configuration: cfg_we with cfg_index 0 writes tcp_mode, index 1 writes
// as_request, from cfg_wdata. Write only while no result is outstanding.
// The result of an rx word is registered into the output queue when that
// word is taken. Throughput: one rx word per cycle while the queue is not
// full; the parser state updates in one pass of logic behind the frame
// registers. A two-word output queue sits behind the parser, so rx stays
// ready while a result waits; rx ready drops only when both queue words
// are held by a stalled receiver.
// Reset: parser waits for the unit id of an RTU frame, all fields zero,
// tcp_mode and as_request cleared, output queue empty.
module modbus_frame_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	mfp_byte_if.sink                        rx,
	mfp_result_if.source                    res,
	input  logic                            cfg_we,
	input  logic [mfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                            cfg_wdata
);

	mfp_pkg::cfg_t cfg_q;
	mfp_pkg::res_t parse_res;
	mfp_pkg::res_t out_res;
	logic          fire;
	logic          q_full;
	logic          q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mfp_pkg::CFG_TCP_MODE:   cfg_q.tcp_mode   <= cfg_wdata;
				mfp_pkg::CFG_AS_REQUEST: cfg_q.as_request <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign rx.ready = !q_full;
	assign fire     = rx.valid && !q_full;

	mfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.func      (rx.func),
		.data_byte (rx.data_byte),
		.cfg       (cfg_q),
		.result    (parse_res)
	);

	mfp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (parse_res),
		.full      (q_full),
		.pop       (q_valid && res.ready),
		.valid     (q_valid),
		.data      (out_res)
	);

	assign res.valid          = q_valid;
	assign res.complete       = out_res.complete;
	assign res.corrupt        = out_res.corrupt;
	assign res.unit_id        = out_res.unit_id;
	assign res.function_code  = out_res.function_code;
	assign res.start_address  = out_res.start_address;
	assign res.quantity       = out_res.quantity;
	assign res.exception_code = out_res.exception_code;
	assign res.transaction_id = out_res.transaction_id;
	assign res.pdu_length     = out_res.pdu_length;
	assign res.crc_word       = out_res.crc_word;
	assign res.bytes_seen     = out_res.bytes_seen;

endmodule
